>>> rtl/vdia_pkg.sv
// Shared types and constants for the vertex deduplication index assigner.
// No dependencies; every other file but vdia_fifo imports this package.
package vdia_pkg;

    // Field widths of one corner and of one result
    localparam int FIELD_W = 15;
    localparam int KEY_W   = 3 * FIELD_W;
    localparam int VIDX_W  = 10;

    // Width of the mesh epoch tag kept with every hash table entry
    localparam int TAG_W   = 8;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // One classified item on its way from the front to the back
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CHECK
    } t_back_state;

    // Status from the back part to the top level
    typedef struct packed {
        logic sweeping;
        logic cmd_taken;
    } t_back_status;

endpackage

>>> rtl/vertex_dedup_index_assigner_core.sv
// A corner passes the front register and the queue; the back part probes the table from its
// hash slot on until it finds the key or a free slot and registers the result. It takes a new
// item only when idle, finishing each first; each probe waits on the single-port table's
// registered read. Reset: control clears at once, then a pass over 2^(clog2(MAX_VERTICES)+1)
// entries clears the table; the same pass follows every 255th clear. No item is taken meanwhile.
// Depends on vdia_pkg, vdia_front, vdia_fifo, vdia_back.
module vertex_dedup_index_assigner_core
    import vdia_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [FIELD_W-1:0] i_position_index,
    input  logic [FIELD_W-1:0] i_normal_index,
    input  logic [FIELD_W-1:0] i_uv_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VIDX_W-1:0]  o_vertex_index,
    output logic               o_is_new,
    output logic               o_table_full
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int HT_AW = VW + 1;
    localparam int Q_W   = $bits(t_cmd) + HT_AW;

    logic             front_valid;
    logic             front_ready;
    t_cmd             front_cmd;
    logic [HT_AW-1:0] front_hash;
    logic             q_valid;
    logic             q_ready;
    logic [Q_W-1:0]   q_data;
    t_cmd             q_cmd;
    logic [HT_AW-1:0] q_hash;
    t_back_status     back_status;

    vdia_front #(
        .HT_AW (HT_AW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_position_index (i_position_index),
        .i_normal_index   (i_normal_index),
        .i_uv_index       (i_uv_index),
        .i_hold           (back_status.sweeping),
        .o_cmd_valid      (front_valid),
        .i_cmd_ready      (front_ready),
        .o_cmd            (front_cmd),
        .o_hash           (front_hash)
    );

    vdia_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  ({front_cmd, front_hash}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign q_cmd  = t_cmd'(q_data[Q_W-1:HT_AW]);
    assign q_hash = q_data[HT_AW-1:0];

    vdia_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .HT_AW        (HT_AW),
        .VW           (VW),
        .CW           (CW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_ready    (q_ready),
        .i_cmd          (q_cmd),
        .i_hash         (q_hash),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_status       (back_status)
    );

    // A full-table result reports index zero and is never a new vertex
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> (o_vertex_index == '0) && !o_is_new)
        else $error("full-table result carries an index or a new flag");

    // No queued item is taken while the table is being swept
    a_sweep_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.sweeping |-> !back_status.cmd_taken)
        else $error("item taken during table sweep");

    // The input side is held off for the whole sweep
    a_sweep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.sweeping |-> !o_ready)
        else $error("input accepted during table sweep");

endmodule

>>> rtl/vdia_front.sv
// Front part: accepts corner and clear items, packs the key and computes its hash slot.
// Depends on vdia_pkg.
module vdia_front
    import vdia_pkg::*;
#(
    parameter int HT_AW = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [FIELD_W-1:0] i_position_index,
    input  logic [FIELD_W-1:0] i_normal_index,
    input  logic [FIELD_W-1:0] i_uv_index,
    input  logic               i_hold,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output t_cmd               o_cmd,
    output logic [HT_AW-1:0]   o_hash
);

    logic             r_valid;
    t_cmd             r_cmd;
    logic [HT_AW-1:0] r_hash;
    t_cmd             n_cmd;
    logic [HT_AW-1:0] n_hash;
    logic             accept;

    // Take a new item when not held and the stage is free or drains this cycle
    assign o_ready = !i_hold && (!r_valid || i_cmd_ready);
    assign accept  = i_valid && o_ready;

    // Classify and pack the triple
    always_comb begin
        n_cmd.op  = t_op'(i_func);
        n_cmd.key = {i_position_index, i_normal_index, i_uv_index};
    end

    // Fold the key into a table address
    always_comb begin
        n_hash = '0;
        for (int b = 0; b < KEY_W; b++) begin
            n_hash[b % HT_AW] = n_hash[b % HT_AW] ^ n_cmd.key[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload until it moves on
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= n_cmd;
            r_hash <= n_hash;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
    assign o_hash      = r_hash;

endmodule

>>> rtl/vdia_fifo.sv
// Small queue between the front and back parts; DEPTH is a power of two.
// Does not depend on vdia_pkg (no types used).
module vdia_fifo #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_fill;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_fill != CW'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/vdia_back.sv
// Back part: hash table with linear probing, epoch-tagged entries, result register.
// Depends on vdia_pkg.
module vdia_back
    import vdia_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int HT_AW        = 11,
    parameter int VW           = 10,
    parameter int CW           = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    input  logic [HT_AW-1:0]   i_hash,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VIDX_W-1:0]  o_vertex_index,
    output logic               o_is_new,
    output logic               o_table_full,
    output t_back_status       o_status
);

    localparam int HT_DEPTH = 1 << HT_AW;
    localparam int ENT_W    = TAG_W + KEY_W + VW;

    // Hash table: {epoch tag, key, vertex index}
    logic [ENT_W-1:0]  r_mem [HT_DEPTH];
    logic [ENT_W-1:0]  r_rd_data;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [TAG_W-1:0]  r_epoch;
    logic [TAG_W-1:0]  n_epoch;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  n_key;
    logic [HT_AW-1:0]  r_addr;
    logic [HT_AW-1:0]  n_addr;
    logic [HT_AW-1:0]  r_sweep_addr;
    logic [HT_AW-1:0]  n_sweep_addr;
    logic              r_out_valid;
    logic [VIDX_W-1:0] r_out_vidx;
    logic              r_out_new;
    logic              r_out_full;
    logic [VIDX_W-1:0] n_out_vidx;
    logic              n_out_new;
    logic              n_out_full;
    logic              load_out;

    logic              rd_en;
    logic [HT_AW-1:0]  rd_addr;
    logic              wr_en;
    logic [HT_AW-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;

    logic [TAG_W-1:0]  ent_tag;
    logic [KEY_W-1:0]  ent_key;
    logic [VW-1:0]     ent_vidx;
    logic              ent_live;
    logic              ent_hit;
    logic              at_cap;
    logic              out_free;
    logic              is_clear;

    // Decode the entry from the last table read
    assign ent_tag  = r_rd_data[ENT_W-1 -: TAG_W];
    assign ent_key  = r_rd_data[VW +: KEY_W];
    assign ent_vidx = r_rd_data[VW-1:0];
    assign ent_live = (ent_tag == r_epoch);
    assign ent_hit  = ent_live && (ent_key == r_key);
    assign at_cap   = (r_count == CW'(MAX_VERTICES));
    assign out_free = !r_out_valid || i_ready;
    assign is_clear = (i_cmd.op == OP_CLEAR);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_sweep_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (!is_clear) begin
                        n_state = ST_CHECK;
                    end else if (r_epoch == '1) begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_CHECK: begin
                if ((ent_hit || !ent_live) && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // Datapath controls per state
    always_comb begin
        o_cmd_ready  = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = {r_epoch, r_key, r_count[VW-1:0]};
        load_out     = 1'b0;
        n_out_vidx   = '0;
        n_out_new    = 1'b0;
        n_out_full   = 1'b0;
        n_epoch      = r_epoch;
        n_count      = r_count;
        n_key        = r_key;
        n_addr       = r_addr;
        n_sweep_addr = r_sweep_addr;
        unique case (r_state)
            ST_SWEEP: begin
                // Invalidate one entry a cycle
                wr_en        = 1'b1;
                wr_addr      = r_sweep_addr;
                wr_data      = '0;
                n_sweep_addr = r_sweep_addr + 1'b1;
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    if (is_clear) begin
                        // New mesh: advance the epoch, restart at vertex zero
                        n_count = '0;
                        n_epoch = (r_epoch == '1) ? TAG_W'(1) : r_epoch + 1'b1;
                    end else begin
                        n_key   = i_cmd.key;
                        n_addr  = i_hash;
                        rd_en   = 1'b1;
                        rd_addr = i_hash;
                    end
                end
            end
            ST_CHECK: begin
                if (ent_hit) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        n_out_vidx = VIDX_W'(ent_vidx);
                    end
                end else if (ent_live) begin
                    // Occupied by another triple: probe the next slot
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                end else if (out_free) begin
                    load_out = 1'b1;
                    if (at_cap) begin
                        n_out_full = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        n_out_vidx = VIDX_W'(r_count[VW-1:0]);
                        n_out_new  = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_epoch      <= TAG_W'(1);
            r_count      <= '0;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_epoch      <= n_epoch;
            r_count      <= n_count;
            r_sweep_addr <= n_sweep_addr;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_addr <= n_addr;
        if (load_out) begin
            r_out_vidx <= n_out_vidx;
            r_out_new  <= n_out_new;
            r_out_full <= n_out_full;
        end
    end

    // Table memory: one write or one read a cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_vertex_index     = r_out_vidx;
    assign o_is_new           = r_out_new;
    assign o_table_full       = r_out_full;
    assign o_status.sweeping  = (r_state == ST_SWEEP);
    assign o_status.cmd_taken = o_cmd_ready && i_cmd_valid;

endmodule
